// ===== src/avg_pkg.sv =====
// Shared types and constants for the arrowhead vertex generator.
// Used by avg_controller, avg_datapath and the top level; no dependencies.
`default_nettype none

package avg_pkg;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int CFG_BITS    = 12;
    localparam int SQRT_STEPS  = 25;
    localparam int DIV_STEPS   = 47;
    localparam int CNT_BITS    = 6;

    // Configuration register indexes.
    localparam logic CFG_HEAD_LENGTH = 1'b0;
    localparam logic CFG_WING_WIDTH  = 1'b1;

    // Multiplier operand selections.
    localparam logic [2:0] MUL_DXDX  = 3'd0;
    localparam logic [2:0] MUL_DYDY  = 3'd1;
    localparam logic [2:0] MUL_AX    = 3'd2;
    localparam logic [2:0] MUL_AY    = 3'd3;
    localparam logic [2:0] MUL_BX    = 3'd4;
    localparam logic [2:0] MUL_BY    = 3'd5;

    // Corner coordinate slots, one division each.
    localparam logic [1:0] RES_LX = 2'd0;
    localparam logic [1:0] RES_LY = 2'd1;
    localparam logic [1:0] RES_RX = 2'd2;
    localparam logic [1:0] RES_RY = 2'd3;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_end;
        logic [1:0] div_sel;
        logic       finish;
    } cmd_t;

endpackage

`default_nettype wire

// ===== src/avg_controller.sv =====
// Sequencer for the arrowhead vertex generator.
// Drives avg_datapath through avg_pkg::cmd_t and owns both stream handshakes.
`default_nettype none

module avg_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output avg_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL_SQ   = 3'd1;
    localparam logic [2:0] ST_SQRT     = 3'd2;
    localparam logic [2:0] ST_MUL_PR   = 3'd3;
    localparam logic [2:0] ST_DIV_INIT = 3'd4;
    localparam logic [2:0] ST_DIV_RUN  = 3'd5;
    localparam logic [2:0] ST_DIV_END  = 3'd6;
    localparam logic [2:0] ST_FIN      = 3'd7;

    logic [2:0]                 state_reg, state_next;
    logic [avg_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0]                 sel_reg, sel_next;
    logic                       oval_reg, oval_next;
    logic                       out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = oval_reg;
    assign out_free      = !oval_reg || m_axis_tready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        sel_next      = sel_reg;
        oval_next     = oval_reg && !m_axis_tready;
        cmd           = '0;
        cmd.div_sel   = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MUL_SQ;
                end
            end
            ST_MUL_SQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = (cnt_reg[0]) ? avg_pkg::MUL_DYDY : avg_pkg::MUL_DXDX;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg[0])
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == avg_pkg::CNT_BITS'(avg_pkg::SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL_PR;
                end
            end
            ST_MUL_PR:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = avg_pkg::MUL_AX + 3'(cnt_reg[1:0]);
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next   = '0;
                    sel_next   = avg_pkg::RES_LX;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == avg_pkg::CNT_BITS'(avg_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:
            begin
                cmd.div_end = 1'b1;
                sel_next    = sel_reg + 1'b1;
                state_next  = (sel_reg == avg_pkg::RES_RY) ? ST_FIN : ST_DIV_INIT;
            end
            ST_FIN:
            begin
                // The result register may still hold an untaken transaction.
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    oval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            oval_reg  <= oval_next;
        end
    end

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> out_free)
        else $error("result overwritten before it was taken");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_MUL_SQ && cnt_reg == '0))
        else $error("accepted item did not start the sequence");

    a_fin_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (sel_reg == avg_pkg::RES_LX))
        else $error("finish reached before all four corner coordinates");

    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("finished result not presented");

endmodule

`default_nettype wire

// ===== src/avg_datapath.sv =====
// Datapath of the arrowhead vertex generator: shared multiplier, bit-serial
// square root and divider, corner, box and change logic. Uses avg_pkg.
`default_nettype none

module avg_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [avg_pkg::CFG_BITS-1:0]        cfg_data,
    input  wire logic [63:0]                         in_data,
    input  wire avg_pkg::cmd_t                       cmd,
    output logic [127:0]                             out_data,
    output logic                                     out_changed
);

    localparam int NW = 48;

    logic [11:0]        len_reg, wid_reg;
    logic signed [15:0] tip_x_reg, tip_y_reg, ref_x_reg, ref_y_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic               zero_reg;
    logic [33:0]        d2_reg;
    logic [49:0]        rad_reg;
    logic [26:0]        srem_reg;
    logic [24:0]        root_reg;
    logic signed [NW-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [46:0]        dvd_reg;
    logic [27:0]        drem_reg;
    logic               neg_reg;
    logic signed [15:0] res_reg [4];
    logic signed [15:0] prev_reg [4];
    logic [127:0]       odata_reg;
    logic               ochg_reg;

    logic signed [26:0] mul_a, mul_b, along, wf;
    logic signed [53:0] prod;
    logic [28:0]        srem_sh, trial;
    logic [26:0]        den;
    logic [27:0]        dv;
    logic [28:0]        drem_sh;
    logic signed [NW-1:0] nsel, num2, quo, qs, refv, sum;
    logic signed [15:0] satv;
    logic signed [15:0] mnx, mxx, mny, mxy;
    logic [16:0]        ew, eh;
    logic [15:0]        bw, bh;
    logic               changed;

    assign along = $signed({2'b00, root_reg}) - $signed({7'b0, len_reg, 8'b0});
    assign wf    = $signed({7'b0, wid_reg, 8'b0});

    always_comb
    begin
        case (cmd.mul_sel)
            avg_pkg::MUL_DXDX: begin mul_a = 27'(dx_reg); mul_b = 27'(dx_reg); end
            avg_pkg::MUL_DYDY: begin mul_a = 27'(dy_reg); mul_b = 27'(dy_reg); end
            avg_pkg::MUL_AX:   begin mul_a = 27'(dx_reg) <<< 1; mul_b = along; end
            avg_pkg::MUL_AY:   begin mul_a = 27'(dy_reg) <<< 1; mul_b = along; end
            avg_pkg::MUL_BX:   begin mul_a = 27'(dy_reg); mul_b = wf; end
            avg_pkg::MUL_BY:   begin mul_a = 27'(dx_reg); mul_b = wf; end
            default:           begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod = mul_a * mul_b;

    // One root bit per step from the next pair of radicand bits.
    assign srem_sh = {srem_reg, rad_reg[49:48]};
    assign trial   = {2'b00, root_reg, 2'b01};

    // For a zero direction the divisor is fixed at two.
    assign den = zero_reg ? 27'd2 : {1'b0, root_reg, 1'b0};
    assign dv  = {den, 1'b0};

    always_comb
    begin
        case (cmd.div_sel)
            avg_pkg::RES_LX: nsel = ax_reg - bx_reg;
            avg_pkg::RES_LY: nsel = ay_reg + by_reg;
            avg_pkg::RES_RX: nsel = ax_reg + bx_reg;
            avg_pkg::RES_RY: nsel = ay_reg - by_reg;
            default:         nsel = '0;
        endcase
    end
    assign num2    = (nsel <<< 1) + $signed({21'b0, den});
    assign drem_sh = {drem_reg, dvd_reg[46]};

    // Floor division of a negative numerator rounds the magnitude up.
    assign quo  = $signed({1'b0, dvd_reg});
    assign qs   = neg_reg ? -(quo + NW'(|drem_reg)) : quo;
    assign refv = cmd.div_sel[0] ? NW'(ref_y_reg) : NW'(ref_x_reg);
    assign sum  = refv + qs;

    always_comb
    begin
        if (sum > NW'(32767))
            satv = 16'sh7fff;
        else if (sum < -NW'(32768))
            satv = -16'sh8000;
        else
            satv = sum[15:0];
    end

    always_comb
    begin
        mnx = tip_x_reg;
        mxx = tip_x_reg;
        mny = tip_y_reg;
        mxy = tip_y_reg;
        if (res_reg[avg_pkg::RES_LX] < mnx) mnx = res_reg[avg_pkg::RES_LX];
        if (res_reg[avg_pkg::RES_RX] < mnx) mnx = res_reg[avg_pkg::RES_RX];
        if (res_reg[avg_pkg::RES_LX] > mxx) mxx = res_reg[avg_pkg::RES_LX];
        if (res_reg[avg_pkg::RES_RX] > mxx) mxx = res_reg[avg_pkg::RES_RX];
        if (res_reg[avg_pkg::RES_LY] < mny) mny = res_reg[avg_pkg::RES_LY];
        if (res_reg[avg_pkg::RES_RY] < mny) mny = res_reg[avg_pkg::RES_RY];
        if (res_reg[avg_pkg::RES_LY] > mxy) mxy = res_reg[avg_pkg::RES_LY];
        if (res_reg[avg_pkg::RES_RY] > mxy) mxy = res_reg[avg_pkg::RES_RY];
    end

    assign ew = 17'(17'(mxx) - 17'(mnx)) + 17'd1;
    assign eh = 17'(17'(mxy) - 17'(mny)) + 17'd1;
    assign bw = ew[16] ? 16'hffff : ew[15:0];
    assign bh = eh[16] ? 16'hffff : eh[15:0];

    assign changed = (res_reg[0] != prev_reg[0]) || (res_reg[1] != prev_reg[1]) ||
                     (res_reg[2] != prev_reg[2]) || (res_reg[3] != prev_reg[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= 12'd10;
            wid_reg  <= 12'd7;
            prev_reg <= '{default: '0};
        end
        else
        begin
            if (cfg_we && cfg_index == avg_pkg::CFG_HEAD_LENGTH)
                len_reg <= cfg_data;
            if (cfg_we && cfg_index == avg_pkg::CFG_WING_WIDTH)
                wid_reg <= cfg_data;
            if (cmd.finish)
                prev_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tip_x_reg <= in_data[15:0];
            tip_y_reg <= in_data[31:16];
            ref_x_reg <= in_data[47:32];
            ref_y_reg <= in_data[63:48];
            dx_reg    <= 17'($signed(in_data[15:0])) - 17'($signed(in_data[47:32]));
            dy_reg    <= 17'($signed(in_data[31:16])) - 17'($signed(in_data[63:48]));
            zero_reg  <= (in_data[15:0] == in_data[47:32]) &&
                         (in_data[31:16] == in_data[63:48]);
            srem_reg  <= '0;
            root_reg  <= '0;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                avg_pkg::MUL_DXDX: d2_reg  <= prod[33:0];
                avg_pkg::MUL_DYDY: rad_reg <= {d2_reg + prod[33:0], 16'b0};
                avg_pkg::MUL_AX:   ax_reg  <= zero_reg ? -$signed({35'b0, len_reg, 1'b0})
                                                       : prod[NW-1:0];
                avg_pkg::MUL_AY:   ay_reg  <= zero_reg ? '0 : prod[NW-1:0];
                avg_pkg::MUL_BX:   bx_reg  <= zero_reg ? '0 : prod[NW-1:0];
                avg_pkg::MUL_BY:   by_reg  <= zero_reg ? $signed({36'b0, wid_reg})
                                                       : prod[NW-1:0];
                default:           d2_reg  <= d2_reg;
            endcase
        end
        if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[47:0], 2'b00};
            if (srem_sh >= trial)
            begin
                srem_reg <= 27'(srem_sh - trial);
                root_reg <= {root_reg[23:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh[26:0];
                root_reg <= {root_reg[23:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            neg_reg  <= num2[NW-1];
            dvd_reg  <= num2[NW-1] ? 47'(-num2) : num2[46:0];
            drem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (drem_sh >= {1'b0, dv})
            begin
                drem_reg <= 28'(drem_sh - {1'b0, dv});
                dvd_reg  <= {dvd_reg[45:0], 1'b1};
            end
            else
            begin
                drem_reg <= drem_sh[27:0];
                dvd_reg  <= {dvd_reg[45:0], 1'b0};
            end
        end
        if (cmd.div_end)
            res_reg[cmd.div_sel] <= satv;
        if (cmd.finish)
        begin
            odata_reg <= {bh, bw, mny, mnx, res_reg[avg_pkg::RES_RY],
                          res_reg[avg_pkg::RES_RX], res_reg[avg_pkg::RES_LY],
                          res_reg[avg_pkg::RES_LX]};
            ochg_reg  <= changed;
        end
    end

    assign out_data    = odata_reg;
    assign out_changed = ochg_reg;

endmodule

`default_nettype wire

// ===== src/arrowhead_vertex_generator.sv =====
// One transaction at a time: a new input is taken only after the result of the last one
// is finished, which takes the bit-serial square root (25 steps) and four sequential
// bit-serial divisions, and the finish waits until the output register is free.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, asynchronous, active low) sets head_length to 10, wing_width
// to 7, clears the previous corners and empties the output register.
`default_nettype none

module arrowhead_vertex_generator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [avg_pkg::CFG_BITS-1:0]   cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tip_x, tip_y, ref_x, ref_y
    input  wire logic [63:0]                    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // left_x, left_y, right_x, right_y, box_x, box_y, box_w, box_h
    output logic [127:0]                        m_axis_tdata,
    // corners_changed
    output logic                                m_axis_tuser
);

    avg_pkg::cmd_t cmd;

    avg_controller u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    avg_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_data     (s_axis_tdata),
        .cmd         (cmd),
        .out_data    (m_axis_tdata),
        .out_changed (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== sim/arrowhead_vertex_generator_test.sv =====
// Self-checking testbench for arrowhead_vertex_generator: drives tip/reference points
// over the input stream and compares each result against an internal fixed-point predictor.
// Depends on avg_pkg and the arrowhead_vertex_generator RTL.
`timescale 1ns / 100ps

module arrowhead_vertex_generator_test;

    localparam int  MAX_CYCLES    = 3_000_000;
    localparam int  LONG_HOLD     = 1500;
    localparam int  SETTLE_CYCLES = 300;

    typedef struct {
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [15:0]        box_w;
        logic [15:0]        box_h;
        logic               changed;
    } arrowhead_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic                         cfg_index = avg_pkg::CFG_HEAD_LENGTH;
    logic [avg_pkg::CFG_BITS-1:0] cfg_data = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [63:0]                  s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [127:0]                 m_axis_tdata;
    logic                         m_axis_tuser;

    // Predictor state.
    logic [avg_pkg::CFG_BITS-1:0] head_len;
    logic [avg_pkg::CFG_BITS-1:0] wing_w;
    logic signed [15:0]  last_lx, last_ly, last_rx, last_ry;

    arrowhead_t expected_corners[$];
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b1;
    bit  long_hold = 1'b0;
    int  hold_count = 0;
    int  stall_left = 0;

    arrowhead_vertex_generator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Nearest integer to n / den with ties toward plus infinity.
    function automatic longint round_div(longint n, longint den);
        longint num = 2 * n + den;
        longint d = 2 * den;
        if (num >= 0)
            return num / d;
        return -((-num + d - 1) / d);
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic arrowhead_t predict_arrowhead(logic signed [15:0] tx, logic signed [15:0] ty,
                                                     logic signed [15:0] rx, logic signed [15:0] ry);
        arrowhead_t res;
        longint dx, dy, len, wid, den, dq, along, wf;
        longint nlx, nly, nrx, nry, lx, ly, qx, qy;
        longint mnx, mxx, mny, mxy, bw, bh;
        dx = longint'(tx) - longint'(rx);
        dy = longint'(ty) - longint'(ry);
        len = longint'(head_len);
        wid = longint'(wing_w);
        if (dx == 0 && dy == 0)
        begin
            // Degenerate direction falls back to +x.
            den = 2;
            nlx = -2 * len;
            nrx = -2 * len;
            nly = wid;
            nry = -wid;
        end
        else
        begin
            dq = longint'(int_sqrt(longint'(dx * dx + dy * dy) << (2 * avg_pkg::FRAC_BITS)));
            along = dq - (len << avg_pkg::FRAC_BITS);
            wf = wid << avg_pkg::FRAC_BITS;
            den = 2 * dq;
            nlx = 2 * dx * along - dy * wf;
            nly = 2 * dy * along + dx * wf;
            nrx = 2 * dx * along + dy * wf;
            nry = 2 * dy * along - dx * wf;
        end
        lx = sat16(longint'(rx) + round_div(nlx, den));
        ly = sat16(longint'(ry) + round_div(nly, den));
        qx = sat16(longint'(rx) + round_div(nrx, den));
        qy = sat16(longint'(ry) + round_div(nry, den));
        res.changed = (lx != last_lx) || (ly != last_ly) || (qx != last_rx) || (qy != last_ry);
        last_lx = 16'(lx);
        last_ly = 16'(ly);
        last_rx = 16'(qx);
        last_ry = 16'(qy);
        mnx = tx; mxx = tx; mny = ty; mxy = ty;
        if (lx < mnx) mnx = lx;
        if (qx < mnx) mnx = qx;
        if (lx > mxx) mxx = lx;
        if (qx > mxx) mxx = qx;
        if (ly < mny) mny = ly;
        if (qy < mny) mny = qy;
        if (ly > mxy) mxy = ly;
        if (qy > mxy) mxy = qy;
        bw = mxx - mnx + 1;
        bh = mxy - mny + 1;
        if (bw > 65535) bw = 65535;
        if (bh > 65535) bh = 65535;
        res.left_x = 16'(lx);
        res.left_y = 16'(ly);
        res.right_x = 16'(qx);
        res.right_y = 16'(qy);
        res.box_x = 16'(mnx);
        res.box_y = 16'(mny);
        res.box_w = 16'(bw);
        res.box_h = 16'(bh);
        return res;
    endfunction

    // Sends one point pair; valid stays high afterward so back-to-back items need no toggle.
    task automatic send_point(logic signed [15:0] tx, logic signed [15:0] ty,
                              logic signed [15:0] rx, logic signed [15:0] ry);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ry, rx, ty, tx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_corners.push_back(predict_arrowhead(tx, ty, rx, ry));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_corners.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [avg_pkg::CFG_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == avg_pkg::CFG_HEAD_LENGTH)
            head_len = val;
        else
            wing_w = val;
    endtask

    task automatic set_arrow_shape(logic [avg_pkg::CFG_BITS-1:0] len,
                                   logic [avg_pkg::CFG_BITS-1:0] wid);
        write_reg(avg_pkg::CFG_HEAD_LENGTH, len);
        write_reg(avg_pkg::CFG_WING_WIDTH, wid);
    endtask

    task automatic send_random_point;
        logic signed [15:0] tx, ty, rx, ry;
        tx = 16'($urandom);
        ty = 16'($urandom);
        case ($urandom_range(0, 9))
            0:
            begin
                rx = tx;
                ry = ty;
            end
            1, 2:
            begin
                rx = 16'($urandom);
                ry = 16'($urandom);
            end
            default:
            begin
                rx = tx + $signed(16'($urandom_range(0, 400)) - 16'd200);
                ry = ty + $signed(16'($urandom_range(0, 400)) - 16'd200);
            end
        endcase
        send_point(tx, ty, rx, ry);
    endtask

    task automatic test_reset_state;
        // Zero wing width makes both corners land on the origin, so no change is flagged.
        write_reg(avg_pkg::CFG_WING_WIDTH, 12'd0);
        send_point(16'sd10, 16'sd0, 16'sd10, 16'sd0);
        drain();
    endtask

    task automatic test_directed;
        set_arrow_shape(12'd10, 12'd7);
        send_point(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd100, 16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd100, 16'sd0, 16'sd0);
        send_point(-16'sd100, 16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd0, -16'sd100, 16'sd0, 16'sd0);
        send_point(16'sd3, 16'sd4, 16'sd0, 16'sd0);
        send_point(16'sd2, 16'sd1, 16'sd0, 16'sd0);
        send_point(16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000);
        send_point(-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff);
        send_point(16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff);
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_point(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        drain();
        set_arrow_shape(12'd4095, 12'd4095);
        send_point(-16'sh8000, 16'sd0, -16'sh8000, 16'sd0);
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_point(16'sd1, 16'sd0, 16'sd0, 16'sd0);
        send_point(16'sh7fff, 16'sd0, -16'sh8000, 16'sd0);
        send_point(16'sd0, -16'sh8000, 16'sd0, 16'sh7fff);
        drain();
        set_arrow_shape(12'd0, 12'd4095);
        send_point(16'sd50, 16'sd50, 16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        drain();
        set_arrow_shape(12'd4095, 12'd0);
        send_point(16'sd50, -16'sd50, 16'sd0, 16'sd0);
        drain();
    endtask

    task automatic test_random_shapes(int count, logic [avg_pkg::CFG_BITS-1:0] len,
                                      logic [avg_pkg::CFG_BITS-1:0] wid);
        set_arrow_shape(len, wid);
        repeat (count) send_random_point();
        drain();
    endtask

    task automatic test_output_backpressure;
        long_hold = 1'b1;
        repeat (8) send_random_point();
        drain();
    endtask

    // Receiver side: random stalls plus an optional long hold-off.
    always @(posedge clk)
    begin
        if (long_hold)
        begin
            m_axis_tready <= 1'b0;
            hold_count++;
            if (hold_count >= LONG_HOLD)
            begin
                long_hold = 1'b0;
                hold_count = 0;
            end
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        arrowhead_t exp_res;
        arrowhead_t got;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.left_x = m_axis_tdata[15:0];
            got.left_y = m_axis_tdata[31:16];
            got.right_x = m_axis_tdata[47:32];
            got.right_y = m_axis_tdata[63:48];
            got.box_x = m_axis_tdata[79:64];
            got.box_y = m_axis_tdata[95:80];
            got.box_w = m_axis_tdata[111:96];
            got.box_h = m_axis_tdata[127:112];
            got.changed = m_axis_tuser;
            if (expected_corners.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction at cycle %0d", cycle_count);
            end
            else
            begin
                exp_res = expected_corners.pop_front();
                if (got.left_x !== exp_res.left_x || got.left_y !== exp_res.left_y ||
                    got.right_x !== exp_res.right_x || got.right_y !== exp_res.right_y ||
                    got.box_x !== exp_res.box_x || got.box_y !== exp_res.box_y ||
                    got.box_w !== exp_res.box_w || got.box_h !== exp_res.box_h ||
                    got.changed !== exp_res.changed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected L(%0d,%0d) R(%0d,%0d) box(%0d,%0d,%0d,%0d) chg %0b, got L(%0d,%0d) R(%0d,%0d) box(%0d,%0d,%0d,%0d) chg %0b",
                                 exp_res.left_x, exp_res.left_y, exp_res.right_x, exp_res.right_y,
                                 exp_res.box_x, exp_res.box_y, exp_res.box_w, exp_res.box_h,
                                 exp_res.changed, got.left_x, got.left_y, got.right_x, got.right_y,
                                 got.box_x, got.box_y, got.box_w, got.box_h, got.changed);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        head_len = 12'd10;
        wing_w = 12'd7;
        last_lx = '0;
        last_ly = '0;
        last_rx = '0;
        last_ry = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_random_shapes(250, 12'd10, 12'd7);
        test_random_shapes(250, 12'd0, 12'd0);
        test_random_shapes(200, 12'd4095, 12'd4095);
        test_random_shapes(250, 12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)));
        test_output_backpressure();
        test_random_shapes(200, 12'($urandom), 12'($urandom));
        idle_on = 1'b0;
        test_random_shapes(300, 12'd25, 12'd16);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
